@@ src/frame_counted_fifo_hysteresis_unit_assert.svh @@
// Assertion macros for the frame counted descriptor FIFO.
// Included by the top level; expects clk and rst in scope.
`ifndef FRAME_COUNTED_FIFO_HYSTERESIS_UNIT_ASSERT_SVH
`define FRAME_COUNTED_FIFO_HYSTERESIS_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define FCFH_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define FCFH_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/fcfh_pkg.sv @@
// Shared types and codes for the frame counted descriptor FIFO.
// Used by the controller, the datapath and the top level; no dependencies.
package fcfh_pkg;

  typedef enum logic [1:0] {
    CMD_ENQ   = 2'd0,
    CMD_PEEK  = 2'd1,
    CMD_DEQ   = 2'd2,
    CMD_PURGE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STS_OK   = 2'd0,
    STS_OVER = 2'd1,
    STS_FULL = 2'd2,
    STS_NONE = 2'd3
  } status_t;

  localparam logic [1:0] REG_FRAME_LIMIT = 2'd0;
  localparam logic [1:0] REG_REFILL_THR  = 2'd1;

  typedef struct packed {
    logic [7:0]  tag;
    logic [15:0] frames;
    logic [15:0] handle;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_PINIT,
    S_P1RD,
    S_P1EV,
    S_P1END,
    S_NONE,
    S_P2RD,
    S_P2EV
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;
    logic exec;
    logic scan_sel;
    logic scan_load;
    logic scan_clr;
    logic idx_inc;
    logic p1_eval;
    logic p1_commit;
    logic p2_move;
    logic emit_purge;
    logic emit_none;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    cmd_t new_cmd;
    logic out_free;
    logic scan_end;
    logic match;
    logic none_removed;
  } dp_stat_t;

endpackage

@@ src/fcfh_ctrl.sv @@
// Sequencer for the descriptor FIFO: single commands and the two-pass purge.
// Depends on fcfh_pkg for the state, command and status types.
module fcfh_ctrl import fcfh_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          state_next = (stat.new_cmd == CMD_PURGE) ? S_PINIT : S_EXEC;
        end
      end
      S_EXEC:  if (stat.out_free) state_next = S_IDLE;
      S_PINIT: state_next = S_P1RD;
      S_P1RD:  state_next = stat.scan_end ? S_P1END : S_P1EV;
      S_P1EV:  state_next = S_P1RD;
      S_P1END: state_next = stat.none_removed ? S_NONE : S_P2RD;
      S_NONE:  if (stat.out_free) state_next = S_IDLE;
      S_P2RD:  state_next = stat.scan_end ? S_IDLE : S_P2EV;
      S_P2EV: begin
        if (!stat.match || stat.out_free) state_next = S_P2RD;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready  = 1'b1;
        cmd.latch = s_tvalid;
      end
      S_EXEC: cmd.exec = stat.out_free;
      S_PINIT: begin
        cmd.scan_sel  = 1'b1;
        cmd.scan_load = 1'b1;
        cmd.scan_clr  = 1'b1;
      end
      S_P1RD: cmd.scan_sel = 1'b1;
      S_P1EV: begin
        cmd.scan_sel = 1'b1;
        cmd.p1_eval  = 1'b1;
        cmd.idx_inc  = 1'b1;
      end
      S_P1END: begin
        cmd.p1_commit = 1'b1;
        cmd.scan_clr  = 1'b1;
      end
      S_NONE: cmd.emit_none = stat.out_free;
      S_P2RD: cmd.scan_sel = 1'b1;
      S_P2EV: begin
        cmd.scan_sel = 1'b1;
        if (stat.match) begin
          cmd.emit_purge = stat.out_free;
          cmd.idx_inc    = stat.out_free;
        end else begin
          cmd.p2_move = 1'b1;
          cmd.idx_inc = 1'b1;
        end
      end
      default: cmd = '0;
    endcase
  end

endmodule

@@ src/fcfh_dp.sv @@
// Datapath for the descriptor FIFO: slot memory, totals, hysteresis flag,
// configuration registers and the output register. Depends on fcfh_pkg.
module fcfh_dp import fcfh_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic [1:0]  cfg_index,
  input  logic [22:0] cfg_data,
  input  logic [39:0] s_tdata,
  input  logic [2:0]  s_tuser,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,
  output logic [2:0]  m_tuser,
  output logic        m_tlast
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;

  logic [22:0]   frame_limit;
  logic [22:0]   refill_thr;
  cmd_t          in_cmd;
  entry_t        in_entry;
  logic          in_all;
  entry_t        mem [DEPTH];
  entry_t        rd_data;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;
  logic [AW-1:0] head, head_next;
  logic [CW-1:0] count, count_next;
  logic [23:0]   total, total_next;
  logic          sat, sat_next;
  logic [CW-1:0] scan_i;
  logic [CW-1:0] scan_len;
  logic [CW-1:0] kept;
  logic [23:0]   removed;
  logic [CW-1:0] last_pos;
  logic          match;
  logic          load_out;
  status_t       res_status;
  logic          res_valid;
  entry_t        res_entry;
  logic          res_last;

  function automatic logic [AW-1:0] slot_at(input logic [AW-1:0] base,
                                            input logic [CW-1:0] pos);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(pos);
    if (sum >= SW'(DEPTH)) sum = sum - SW'(DEPTH);
    return sum[AW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_limit <= '0;
      refill_thr  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_FRAME_LIMIT: frame_limit <= cfg_data;
        REG_REFILL_THR:  refill_thr  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      in_cmd   <= cmd_t'(s_tuser[1:0]);
      in_all   <= s_tuser[2];
      in_entry <= entry_t'(s_tdata);
    end
  end

  // Slot memory; the read port is registered and sees the old data on a
  // same-address write.
  assign rd_addr = cmd.scan_sel ? slot_at(head, scan_i) : head;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  assign match = in_all || (rd_data.tag == in_entry.tag);

  always_comb begin
    head_next  = head;
    count_next = count;
    total_next = total;
    sat_next   = sat;
    wr_en      = 1'b0;
    wr_addr    = slot_at(head, kept);
    wr_data    = rd_data;
    res_status = STS_OK;
    res_valid  = 1'b0;
    res_entry  = rd_data;
    res_last   = 1'b1;
    if (cmd.exec) begin
      case (in_cmd)
        CMD_ENQ: begin
          if (total > {1'b0, frame_limit}) begin
            res_status = STS_OVER;
          end else if (count == CW'(DEPTH)) begin
            res_status = STS_FULL;
          end else begin
            wr_en      = 1'b1;
            wr_addr    = slot_at(head, count);
            wr_data    = in_entry;
            count_next = count + 1'b1;
            total_next = total + 24'(in_entry.frames);
          end
        end
        CMD_PEEK, CMD_DEQ: begin
          res_status = STS_NONE;
          if (refill_thr == '0) begin
            if (count != '0) res_status = STS_OK;
          end else if (count == '0) begin
            sat_next = 1'b0;
          end else if (!(total < {1'b0, refill_thr}) || sat) begin
            sat_next   = 1'b1;
            res_status = STS_OK;
          end
          if (res_status == STS_OK) begin
            res_valid = 1'b1;
            if (in_cmd == CMD_DEQ) begin
              total_next = total - 24'(rd_data.frames);
              count_next = count - 1'b1;
              head_next  = (head == AW'(DEPTH - 1)) ? '0 : head + 1'b1;
            end
          end
        end
        default: res_status = STS_NONE;
      endcase
    end
    if (cmd.p1_commit) begin
      count_next = kept;
      total_next = total - removed;
    end
    if (cmd.p2_move) wr_en = 1'b1;
    if (cmd.emit_purge) begin
      res_valid = 1'b1;
      res_last  = (scan_i == last_pos);
    end
    if (cmd.emit_none) res_status = STS_NONE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
      total <= '0;
      sat   <= 1'b0;
    end else begin
      head  <= head_next;
      count <= count_next;
      total <= total_next;
      sat   <= sat_next;
    end
  end

  // Purge scan bookkeeping. The first pass counts what stays and the frames
  // removed, so every purge result can carry the final totals.
  always_ff @(posedge clk) begin
    if (cmd.scan_load) scan_len <= count;
    if (cmd.scan_clr) begin
      scan_i  <= '0;
      kept    <= '0;
      removed <= '0;
    end else begin
      if (cmd.idx_inc) scan_i <= scan_i + 1'b1;
      if ((cmd.p1_eval && !match) || cmd.p2_move) kept <= kept + 1'b1;
      if (cmd.p1_eval && match) removed <= removed + 24'(rd_data.frames);
    end
    if (cmd.p1_eval && match) last_pos <= scan_i;
  end

  assign load_out = cmd.exec || cmd.emit_purge || cmd.emit_none;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= {3'b000, 5'(count_next), total_next,
                  res_valid ? res_entry : entry_t'('0)};
      m_tuser <= {res_valid, res_status};
      m_tlast <= res_last;
    end
  end

  assign stat.new_cmd      = cmd_t'(s_tuser[1:0]);
  assign stat.out_free     = !m_tvalid || m_tready;
  assign stat.scan_end     = (scan_i == scan_len);
  assign stat.match        = match;
  assign stat.none_removed = (kept == scan_len);

endmodule

@@ src/frame_counted_fifo_hysteresis_unit.sv @@
// Top level of the frame counted descriptor FIFO with refill hysteresis.
// Depends on fcfh_pkg, fcfh_ctrl, fcfh_dp and the assertion macro header.
//
//   channel  signals                        carries
//   cfg      cfg_valid/ready, index, data   register writes
//   s_*      tvalid/tready, tdata, tuser    commands with descriptors
//   m_*      tvalid/tready, tdata, tuser    results, tlast on the final one
//
// Enqueue, peek and dequeue take the transfer and then an execute step
// against the slot memory's registered read port, held while a result waits.
// Purge makes two passes over the N queued entries, a read and an evaluate
// step per entry, or only the first when nothing matches; result-side stalls can hold it.
// Reset is synchronous and empties the queue; no clearing pass is needed.
// A result waits in the output register; the next command is taken meanwhile.
`include "frame_counted_fifo_hysteresis_unit_assert.svh"

module frame_counted_fifo_hysteresis_unit import fcfh_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [22:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,  // handle[15:0], frames[31:16], owner_tag[39:32]
  input  logic [2:0]  s_tuser,  // cmd[1:0], purge_all[2]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,  // out_handle[15:0], out_frames[31:16], out_tag[39:32],
                                // queued_frames[63:40], queued_entries[68:64], zero[71:69]
  output logic [2:0]  m_tuser,  // status[1:0], valid_res[2]
  output logic        m_tlast
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  assign cfg_ready = 1'b1;

  fcfh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (dp_stat),
    .cmd      (dp_cmd)
  );

  fcfh_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cmd       (dp_cmd),
    .stat      (dp_stat),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  `FCFH_ASSERT_IMPL(a_valid_is_ok, m_tvalid && m_tuser[2], m_tuser[1:0] == STS_OK, "descriptor returned with a failing status")
  `FCFH_ASSERT_IMPL(a_empty_is_zero, m_tvalid && !m_tuser[2], m_tdata[39:0] == 40'd0, "descriptor fields not zero without an entry")
  `FCFH_ASSERT_IMPL(a_idle_quiet, s_tready, !(dp_cmd.exec || dp_cmd.emit_purge || dp_cmd.emit_none), "result produced while waiting for a command")
  `FCFH_ASSERT_IMPL(a_no_overwrite, dp_cmd.exec || dp_cmd.emit_purge || dp_cmd.emit_none, !m_tvalid || m_tready, "pending result overwritten")
  `FCFH_ASSERT_NEXT(a_accept_starts, s_tvalid && s_tready, !s_tready, "command accepted without leaving idle")

endmodule
